FILE: rtl/core/ecc_pkg.sv
`default_nettype none

package ecc_pkg;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned DAYS_W  = 20;
  localparam int unsigned DNUM_W  = 21;
  localparam int unsigned SOD_W   = 17;
  localparam int unsigned REM_W   = 17;
  localparam int unsigned QUO_W   = 6;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 12;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [HOUR_W-1:0]  hour_t;
  typedef logic [MIN_W-1:0]   min_t;
  typedef logic [SEC_W-1:0]   sec_t;
  typedef logic [DAYS_W-1:0]  days_t;
  typedef logic [DNUM_W-1:0]  dnum_t;
  typedef logic [SOD_W-1:0]   sod_t;
  typedef logic [REM_W-1:0]   rem_t;
  typedef logic [QUO_W-1:0]   quo_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_EVENT_YEAR   = 3'd0,
    REG_EVENT_MONTH  = 3'd1,
    REG_EVENT_DAY    = 3'd2,
    REG_EVENT_HOUR   = 3'd3,
    REG_EVENT_MINUTE = 3'd4
  } cfg_reg_t;

  localparam year_t  RST_YEAR   = 12'd2022;
  localparam month_t RST_MONTH  = 4'd5;
  localparam day_t   RST_DAY    = 5'd17;
  localparam hour_t  RST_HOUR   = 5'd10;
  localparam min_t   RST_MINUTE = 6'd56;

  localparam rem_t  SEC_PER_DAY = 17'd86400;
  localparam rem_t  REM_SAT     = 17'd86399;
  localparam days_t DAYS_SAT    = 20'hFFFFF;

  typedef struct packed {
    days_t days;
    rem_t  rem;
    logic  passed;
  } split_t;

  // cumulative days before month, month clamped to 1..12
  function automatic logic [8:0] cum_days(input month_t m);
    logic [8:0] c;
    unique case (m)
      4'd0, 4'd1: c = 9'd0;
      4'd2:       c = 9'd31;
      4'd3:       c = 9'd59;
      4'd4:       c = 9'd90;
      4'd5:       c = 9'd120;
      4'd6:       c = 9'd151;
      4'd7:       c = 9'd181;
      4'd8:       c = 9'd212;
      4'd9:       c = 9'd243;
      4'd10:      c = 9'd273;
      4'd11:      c = 9'd304;
      default:    c = 9'd334;
    endcase
    return c;
  endfunction

  // floor(y / 100) by reciprocal
  function automatic quo_t div100(input year_t y);
    logic [24:0] p;
    p = 25'(y) * 25'd5243;
    return p[24:19];
  endfunction

  function automatic sod_t sec_of_day(input hour_t h, input min_t mi, input sec_t s);
    return sod_t'(h) * 17'd3600 + sod_t'(mi) * 17'd60 + sod_t'(s);
  endfunction

  // floor(r / 3600) for r < 86400, as floor((r >> 4) / 225)
  function automatic hour_t div3600(input rem_t r);
    logic [25:0] p;
    p = 26'(r[16:4]) * 26'd4661;
    return p[24:20];
  endfunction

  // floor(r / 60) for r < 3600, as floor((r >> 2) / 15)
  function automatic min_t div60(input logic [11:0] r);
    logic [21:0] p;
    p = 22'(r[11:2]) * 22'd2185;
    return p[20:15];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ecc_split.sv
`default_nettype none

module ecc_split (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ecc_pkg::split_t   in_item,
  output logic              out_valid,
  output ecc_pkg::days_t    out_days,
  output ecc_pkg::hour_t    out_hours,
  output ecc_pkg::min_t     out_minutes,
  output ecc_pkg::sec_t     out_seconds,
  output logic              out_passed
);
  import ecc_pkg::*;

  logic        v5_r, v6_r, v7_r;
  rem_t        rem5_r;
  hour_t       hr5_r, hr6_r, hr7_r;
  days_t       days5_r, days6_r, days7_r;
  logic        pas5_r, pas6_r, pas7_r;
  logic [11:0] r6_nxt, r6_r;
  min_t        min6_r, min7_r;
  sec_t        sec7_nxt, sec7_r;
  rem_t        hsec;
  logic [11:0] msec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v5_r <= in_valid;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // hours
  always_ff @(posedge clk) begin
    rem5_r  <= in_item.rem;
    hr5_r   <= div3600(in_item.rem);
    days5_r <= in_item.days;
    pas5_r  <= in_item.passed;
  end

  // minutes
  always_comb begin
    hsec   = rem_t'(hr5_r) * 17'd3600;
    r6_nxt = 12'(rem5_r - hsec);
  end

  always_ff @(posedge clk) begin
    r6_r    <= r6_nxt;
    min6_r  <= div60(r6_nxt);
    hr6_r   <= hr5_r;
    days6_r <= days5_r;
    pas6_r  <= pas5_r;
  end

  // seconds
  always_comb begin
    msec     = 12'(min6_r) * 12'd60;
    sec7_nxt = 6'(r6_r - msec);
  end

  always_ff @(posedge clk) begin
    sec7_r  <= sec7_nxt;
    min7_r  <= min6_r;
    hr7_r   <= hr6_r;
    days7_r <= days6_r;
    pas7_r  <= pas6_r;
  end

  assign out_valid   = v7_r;
  assign out_days    = days7_r;
  assign out_hours   = hr7_r;
  assign out_minutes = min7_r;
  assign out_seconds = sec7_r;
  assign out_passed  = pas7_r;

endmodule

`default_nettype wire

FILE: rtl/core/event_countdown_calc_core.sv
// channel   ports                                 handshake
// in        start, busy, in_now_*                 start & !busy
// out       out_valid, out_*_left, out_event_*    out_valid, one cycle, no stall
// cfg       cfg_valid, cfg_ready, cfg_index/data  cfg_valid & cfg_ready
//
// one item per cycle; the result is registered through the
// seven register stages (quotients, day numbers, difference, normalize,
// hours, minutes, seconds)
// reset is synchronous, active low; busy and !cfg_ready are high while in reset
// nothing stalls: busy stays low outside reset
`default_nettype none

module event_countdown_calc_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ecc_pkg::year_t         in_now_year,
  input  ecc_pkg::month_t        in_now_month,
  input  ecc_pkg::day_t          in_now_day,
  input  ecc_pkg::hour_t         in_now_hour,
  input  ecc_pkg::min_t          in_now_minute,
  input  ecc_pkg::sec_t          in_now_second,
  output logic                   out_valid,
  output ecc_pkg::days_t         out_days_left,
  output ecc_pkg::hour_t         out_hours_left,
  output ecc_pkg::min_t          out_minutes_left,
  output ecc_pkg::sec_t          out_seconds_left,
  output logic                   out_event_passed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ecc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [ecc_pkg::CDAT_W-1:0] cfg_data
);
  import ecc_pkg::*;

  logic   busy_r;
  year_t  ev_year_r;
  month_t ev_month_r;
  day_t   ev_day_r;
  hour_t  ev_hour_r;
  min_t   ev_minute_r;

  logic   v1_r, v2_r, v3_r, v4_r;
  year_t  n_y_r, e_y_r;
  quo_t   n_q_r, e_q_r;
  month_t n_m_r, e_m_r;
  day_t   n_d_r, e_d_r;
  sod_t   n_sod_r, e_sod_r;

  dnum_t  n_dn_nxt, e_dn_nxt, n_dn_r, e_dn_r;
  logic signed [SOD_W:0] ds_nxt, ds_r;

  logic signed [DNUM_W:0] dd_nxt, dd_r;
  logic [SOD_W+1:0]       x3;
  logic [1:0]             q_nxt, q_r;
  rem_t                   rem_nxt, rem_r;

  logic signed [DNUM_W+1:0] days4;
  logic                     sat4, pas4;
  split_t                   s4_nxt, s4_r;

  logic accept;

  function automatic dnum_t day_num(input year_t y, input quo_t q, input month_t m,
                                    input day_t d);
    logic  nz, leap, extra;
    dnum_t leaps, n;
    nz    = ({1'b0, y} != 13'(q) * 13'd100);
    leap  = (y[1:0] == 2'd0) && (nz || (q[1:0] == 2'd0));
    extra = (m > 4'd2) && leap;
    leaps = dnum_t'(13'(y) + 13'd3 >> 2) - dnum_t'(q) - dnum_t'(nz)
          + dnum_t'(q[QUO_W-1:2]) + dnum_t'(nz || (q[1:0] != 2'd0));
    n     = dnum_t'(y) * dnum_t'(365) + leaps + dnum_t'(cum_days(m))
          + dnum_t'(d) + dnum_t'(extra);
    return n;
  endfunction

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_year_r   <= RST_YEAR;
      ev_month_r  <= RST_MONTH;
      ev_day_r    <= RST_DAY;
      ev_hour_r   <= RST_HOUR;
      ev_minute_r <= RST_MINUTE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EVENT_YEAR:   ev_year_r   <= cfg_data;
        REG_EVENT_MONTH:  ev_month_r  <= cfg_data[MONTH_W-1:0];
        REG_EVENT_DAY:    ev_day_r    <= cfg_data[DAY_W-1:0];
        REG_EVENT_HOUR:   ev_hour_r   <= cfg_data[HOUR_W-1:0];
        REG_EVENT_MINUTE: ev_minute_r <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1: century quotients and second of day
  always_ff @(posedge clk) begin
    n_y_r   <= in_now_year;
    n_q_r   <= div100(in_now_year);
    n_m_r   <= in_now_month;
    n_d_r   <= in_now_day;
    n_sod_r <= sec_of_day(in_now_hour, in_now_minute, in_now_second);
    e_y_r   <= ev_year_r;
    e_q_r   <= div100(ev_year_r);
    e_m_r   <= ev_month_r;
    e_d_r   <= ev_day_r;
    e_sod_r <= sec_of_day(ev_hour_r, ev_minute_r, 6'd0);
  end

  // stage 2: day numbers, second-of-day difference
  always_comb begin
    n_dn_nxt = day_num(n_y_r, n_q_r, n_m_r, n_d_r);
    e_dn_nxt = day_num(e_y_r, e_q_r, e_m_r, e_d_r);
    ds_nxt   = $signed({1'b0, e_sod_r}) - $signed({1'b0, n_sod_r});
  end

  always_ff @(posedge clk) begin
    n_dn_r <= n_dn_nxt;
    e_dn_r <= e_dn_nxt;
    ds_r   <= ds_nxt;
  end

  // stage 3: day difference, fold seconds into one day
  always_comb begin
    dd_nxt = $signed({1'b0, e_dn_r}) - $signed({1'b0, n_dn_r});
    x3     = 19'($signed({ds_r[SOD_W], ds_r}) + 19'sd172800);
    priority if (x3 >= 19'd259200) begin
      q_nxt = 2'd3;
    end else if (x3 >= 19'd172800) begin
      q_nxt = 2'd2;
    end else if (x3 >= 19'd86400) begin
      q_nxt = 2'd1;
    end else begin
      q_nxt = 2'd0;
    end
    rem_nxt = 17'(x3 - 19'(q_nxt) * 19'd86400);
  end

  always_ff @(posedge clk) begin
    dd_r  <= dd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  // stage 4: whole days, passed and saturation
  always_comb begin
    days4 = $signed({dd_r[DNUM_W], dd_r}) + $signed({21'd0, q_r}) - 23'sd2;
    pas4  = days4[DNUM_W+1] || ((days4 == '0) && (rem_r == '0));
    sat4  = !days4[DNUM_W+1] && (days4[DNUM_W:DAYS_W] != '0);
    if (pas4) begin
      s4_nxt.days = '0;
      s4_nxt.rem  = '0;
    end else if (sat4) begin
      s4_nxt.days = DAYS_SAT;
      s4_nxt.rem  = REM_SAT;
    end else begin
      s4_nxt.days = days4[DAYS_W-1:0];
      s4_nxt.rem  = rem_r;
    end
    s4_nxt.passed = pas4;
  end

  always_ff @(posedge clk) begin
    s4_r <= s4_nxt;
  end

  ecc_split u_split (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v4_r),
    .in_item     (s4_r),
    .out_valid   (out_valid),
    .out_days    (out_days_left),
    .out_hours   (out_hours_left),
    .out_minutes (out_minutes_left),
    .out_seconds (out_seconds_left),
    .out_passed  (out_event_passed)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ecc_checker.sv
`default_nettype none

module ecc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [19:0] out_days_left,
  input logic [4:0] out_hours_left,
  input logic [5:0] out_minutes_left,
  input logic [5:0] out_seconds_left,
  input logic       out_event_passed
);
  localparam int unsigned LAT = 7;

  logic acc;
  assign acc = start && !busy && rst_n;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("item gave no result");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result without item");

  a_passed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_passed) |->
      (out_days_left == '0 && out_hours_left == '0 &&
       out_minutes_left == '0 && out_seconds_left == '0))
    else $error("passed result with counts");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hours_left <= 5'd23 && out_minutes_left <= 6'd59 &&
                   out_seconds_left <= 6'd59))
    else $error("split out of range");

endmodule

bind event_countdown_calc_core ecc_checker u_ecc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_days_left    (out_days_left),
  .out_hours_left   (out_hours_left),
  .out_minutes_left (out_minutes_left),
  .out_seconds_left (out_seconds_left),
  .out_event_passed (out_event_passed)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ecc_pkg::*;

  localparam int unsigned PIPE_DEPTH    = 7;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned BATCHES       = 4;
  localparam int unsigned BATCH_ITEMS   = 160;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SPARE_IDX_LO  = int'(REG_EVENT_MINUTE) + 1;
  localparam int unsigned SPARE_IDX_HI  = (1 << CIDX_W) - 1;
  localparam hour_t SAT_HOURS   = 5'd23;
  localparam min_t  SAT_MINUTES = 6'd59;
  localparam sec_t  SAT_SECONDS = 6'd59;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
    hour_t  hour;
    min_t   minute;
    sec_t   second;
  } stamp_t;

  typedef struct packed {
    days_t days;
    hour_t hours;
    min_t  minutes;
    sec_t  seconds;
    logic  passed;
  } countdown_t;

  class countdown_board;
    year_t  ev_year;
    month_t ev_month;
    day_t   ev_day;
    hour_t  ev_hour;
    min_t   ev_minute;
    countdown_t pending[$];
    int unsigned fail_count;
    int unsigned month_base[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

    function new();
      ev_year    = RST_YEAR;
      ev_month   = RST_MONTH;
      ev_day     = RST_DAY;
      ev_hour    = RST_HOUR;
      ev_minute  = RST_MINUTE;
      fail_count = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
      case (idx)
        REG_EVENT_YEAR:   ev_year   = data[YEAR_W-1:0];
        REG_EVENT_MONTH:  ev_month  = data[MONTH_W-1:0];
        REG_EVENT_DAY:    ev_day    = data[DAY_W-1:0];
        REG_EVENT_HOUR:   ev_hour   = data[HOUR_W-1:0];
        REG_EVENT_MINUTE: ev_minute = data[MIN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_leap(longint unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days since jan 1 of year 0, month clamped to 1..12
    function longint unsigned day_count(longint unsigned y, longint unsigned m,
                                        longint unsigned d);
      longint unsigned leaps;
      longint unsigned n;
      leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      n = y * 365 + leaps + month_base[m - 1] + d;
      if (m > 2 && is_leap(y)) n++;
      return n;
    endfunction

    function longint abs_seconds(longint unsigned y, longint unsigned mo, longint unsigned d,
                                 longint unsigned h, longint unsigned mi, longint unsigned s);
      return longint'(day_count(y, mo, d) * SECS_PER_DAY + h * SECS_PER_HOUR
                      + mi * SECS_PER_MIN + s);
    endfunction

    function countdown_t predict_countdown(stamp_t stamp);
      longint remain;
      longint unsigned whole_days;
      longint unsigned day_secs;
      countdown_t r;
      remain = abs_seconds(ev_year, ev_month, ev_day, ev_hour, ev_minute, 0)
             - abs_seconds(stamp.year, stamp.month, stamp.day, stamp.hour,
                           stamp.minute, stamp.second);
      r = '0;
      if (remain <= 0) begin
        r.passed = 1'b1;
      end else begin
        whole_days = longint'(remain) / SECS_PER_DAY;
        day_secs   = longint'(remain) % SECS_PER_DAY;
        if (whole_days > DAYS_SAT) begin
          r.days    = DAYS_SAT;
          r.hours   = SAT_HOURS;
          r.minutes = SAT_MINUTES;
          r.seconds = SAT_SECONDS;
        end else begin
          r.days    = days_t'(whole_days);
          r.hours   = hour_t'(day_secs / SECS_PER_HOUR);
          r.minutes = min_t'((day_secs % SECS_PER_HOUR) / SECS_PER_MIN);
          r.seconds = sec_t'(day_secs % SECS_PER_MIN);
        end
      end
      return r;
    endfunction

    function void note_sample(stamp_t stamp);
      pending.push_back(predict_countdown(stamp));
    endfunction

    function void check_countdown(countdown_t got);
      countdown_t want;
      if (pending.size() == 0) begin
        $error("result with no item outstanding: days_left %0d", got.days);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (got.days !== want.days) begin
        $error("days_left: expected %0d, got %0d", want.days, got.days);
        fail_count++;
      end
      if (got.hours !== want.hours) begin
        $error("hours_left: expected %0d, got %0d", want.hours, got.hours);
        fail_count++;
      end
      if (got.minutes !== want.minutes) begin
        $error("minutes_left: expected %0d, got %0d", want.minutes, got.minutes);
        fail_count++;
      end
      if (got.seconds !== want.seconds) begin
        $error("seconds_left: expected %0d, got %0d", want.seconds, got.seconds);
        fail_count++;
      end
      if (got.passed !== want.passed) begin
        $error("event_passed: expected %0d, got %0d", want.passed, got.passed);
        fail_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  year_t  in_now_year;
  month_t in_now_month;
  day_t   in_now_day;
  hour_t  in_now_hour;
  min_t   in_now_minute;
  sec_t   in_now_second;
  logic   out_valid;
  days_t  out_days_left;
  hour_t  out_hours_left;
  min_t   out_minutes_left;
  sec_t   out_seconds_left;
  logic   out_event_passed;
  logic   cfg_valid;
  logic   cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CDAT_W-1:0] cfg_data;

  countdown_board board = new();
  int unsigned idle_pct;
  int unsigned cycle_count = 0;
  int unsigned idle_plan[3] = '{6, 67, 0};

  event_countdown_calc_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_now_year      (in_now_year),
    .in_now_month     (in_now_month),
    .in_now_day       (in_now_day),
    .in_now_hour      (in_now_hour),
    .in_now_minute    (in_now_minute),
    .in_now_second    (in_now_second),
    .out_valid        (out_valid),
    .out_days_left    (out_days_left),
    .out_hours_left   (out_hours_left),
    .out_minutes_left (out_minutes_left),
    .out_seconds_left (out_seconds_left),
    .out_event_passed (out_event_passed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[event_countdown_calc_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
      board.set_reg(cfg_index, cfg_data);
    end
    if (start === 1'b1 && busy === 1'b0) begin
      board.note_sample('{year: in_now_year, month: in_now_month, day: in_now_day,
                          hour: in_now_hour, minute: in_now_minute,
                          second: in_now_second});
    end
    if (out_valid === 1'b1) begin
      board.check_countdown('{days: out_days_left, hours: out_hours_left,
                              minutes: out_minutes_left, seconds: out_seconds_left,
                              passed: out_event_passed});
    end
  end

  function automatic stamp_t make_stamp(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s);
    return '{year: year_t'(y), month: month_t'(mo), day: day_t'(d),
             hour: hour_t'(h), minute: min_t'(mi), second: sec_t'(s)};
  endfunction

  // item stays on the bus until taken; start is left high
  task automatic drive_item(input stamp_t s);
    start         <= 1'b1;
    in_now_year   <= s.year;
    in_now_month  <= s.month;
    in_now_day    <= s.day;
    in_now_hour   <= s.hour;
    in_now_minute <= s.minute;
    in_now_second <= s.second;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic sender_gaps();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // upper data bits of the month, day, hour and minute writes are junk, only the field bits should land
  task automatic program_event(input year_t y, input month_t m, input day_t d,
                               input hour_t h, input min_t mi);
    settle();
    cfg_write(REG_EVENT_YEAR, y);
    cfg_write(REG_EVENT_MONTH, {8'($urandom), m});
    cfg_write(REG_EVENT_DAY, {7'($urandom), d});
    cfg_write(REG_EVENT_HOUR, {7'($urandom), h});
    if ($urandom_range(2) == 0) begin
      cfg_write(CIDX_W'($urandom_range(SPARE_IDX_HI, SPARE_IDX_LO)), CDAT_W'($urandom));
    end
    cfg_write(REG_EVENT_MINUTE, {6'($urandom), mi});
    cfg_valid <= 1'b0;
  endtask

  task automatic program_random_event();
    year_t  y;
    month_t m;
    day_t   d;
    hour_t  h;
    min_t   mi;
    y  = ($urandom_range(3) != 0) ? year_t'($urandom_range(4095, 1900)) : year_t'($urandom);
    m  = ($urandom_range(4) != 0) ? month_t'($urandom_range(12, 1)) : month_t'($urandom);
    d  = ($urandom_range(4) != 0) ? day_t'($urandom_range(31, 1)) : day_t'($urandom);
    h  = ($urandom_range(4) != 0) ? hour_t'($urandom_range(23)) : hour_t'($urandom);
    mi = ($urandom_range(4) != 0) ? min_t'($urandom_range(59)) : min_t'($urandom);
    program_event(y, m, d, h, mi);
  endtask

  task automatic drive_random_item();
    stamp_t s;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // close to the event so countdowns and crossings both show up
      s.year   = board.ev_year + year_t'($urandom_range(2)) - year_t'(1);
      s.month  = $urandom_range(1) ? board.ev_month : month_t'($urandom_range(12, 1));
      s.day    = $urandom_range(1) ? board.ev_day : day_t'($urandom_range(31, 1));
      s.hour   = $urandom_range(1) ? board.ev_hour : hour_t'($urandom_range(23));
      s.minute = $urandom_range(1) ? board.ev_minute : min_t'($urandom_range(59));
      s.second = sec_t'($urandom_range(60));
    end else if (pick < 80) begin
      s = make_stamp($urandom_range(4095, 1900), $urandom_range(12, 1), $urandom_range(31, 1),
                     $urandom_range(23), $urandom_range(59), $urandom_range(60));
    end else begin
      s = stamp_t'({$urandom, $urandom});
    end
    drive_item(s);
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_now_year   <= '0;
    in_now_month  <= '0;
    in_now_day    <= '0;
    in_now_hour   <= '0;
    in_now_minute <= '0;
    in_now_second <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    idle_pct      = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset event setting
    drive_item(make_stamp(2022, 5, 17, 10, 56, 0));
    drive_item(make_stamp(2022, 5, 17, 10, 55, 59));
    drive_item(make_stamp(2022, 5, 17, 10, 55, 60));
    drive_item(make_stamp(2022, 5, 17, 10, 56, 1));
    drive_item(make_stamp(2022, 5, 16, 10, 56, 0));
    drive_item(make_stamp(0, 1, 1, 0, 0, 0));
    drive_item(make_stamp(4095, 15, 31, 31, 63, 63));
    drive_item(make_stamp(2022, 0, 17, 10, 56, 0));
    drive_item(make_stamp(2021, 15, 31, 23, 59, 59));
    drive_item(make_stamp(2022, 5, 0, 0, 0, 0));
    drive_item(make_stamp(2022, 2, 31, 0, 0, 0));
    drive_item(make_stamp(2022, 5, 16, 31, 63, 63));
    drive_item(make_stamp(2000, 2, 29, 12, 0, 0));
    drive_item(make_stamp(1900, 3, 1, 0, 0, 0));
    drive_item(make_stamp(2020, 3, 1, 0, 0, 0));

    // far event, days saturate for the earliest stamps
    program_event(year_t'(4095), month_t'(12), day_t'(31), hour_t'(23), min_t'(59));
    drive_item(make_stamp(0, 0, 0, 0, 0, 0));
    drive_item(make_stamp(1200, 1, 1, 0, 0, 0));
    drive_item(make_stamp(1300, 1, 1, 0, 0, 0));
    drive_item(make_stamp(2100, 2, 29, 0, 0, 0));

    // all event fields at their top codes
    program_event('1, '1, '1, '1, '1);
    drive_item(make_stamp(4095, 12, 31, 31, 63, 0));
    drive_item(make_stamp(4095, 12, 31, 31, 62, 59));

    // all event fields zero
    program_event('0, '0, '0, '0, '0);
    drive_item(make_stamp(0, 0, 0, 0, 0, 0));
    drive_item(make_stamp(0, 1, 0, 0, 0, 0));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = idle_plan[phase];
      for (int batch = 0; batch < BATCHES; batch++) begin
        program_random_event();
        for (int n = 0; n < BATCH_ITEMS; n++) begin
          if (phase == 0 && batch == 0 && n == BATCH_ITEMS / 2) settle();
          sender_gaps();
          drive_random_item();
        end
      end
    end

    settle();
    if (board.fail_count == 0) begin
      $display("[event_countdown_calc_core] OK");
    end else begin
      $display("[event_countdown_calc_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: event_countdown_calc_core.f
rtl/core/ecc_pkg.sv
rtl/core/ecc_split.sv
rtl/core/event_countdown_calc_core.sv
rtl/core/ecc_checker.sv
tb/tb_top.sv
